// ===== sv/scs_pkg.sv =====
`timescale 1ns / 1ps
package scs_pkg;

	localparam logic [1:0] MODE_CODE   = 2'd0;
	localparam logic [1:0] MODE_STRING = 2'd1;
	localparam logic [1:0] MODE_BLOCK  = 2'd2;
	localparam logic [1:0] MODE_LINE   = 2'd3;

	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	localparam int RUN_W = 10;

	// result queue: two slots per input beat plus room to keep streaming
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [RUN_W-1:0] space_run;
		logic             has_char;
		logic [7:0]       out_char;
		logic             last;
	} result_t;

endpackage

// ===== sv/source_comment_stripper.sv =====
`timescale 1ns / 1ps
// A result is held in the result queue from the cycle after its byte is accepted.
// Throughput: one byte per cycle unless in_stall; a byte that yields two results
// needs two output beats, so the four-entry result queue sets the sustained rate
// under output stall. in_stall rises while fewer than two queue slots are free.
// Reset (arst_n low, asynchronous) returns to code mode with no slash, star or
// spaces held and an empty result queue.
module source_comment_stripper
	import scs_pkg::*;
#(
	parameter int MAX_SPACE_RUN = 1023
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       in_char,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [RUN_W-1:0] space_run,
	output logic             has_char,
	output logic [7:0]       out_char,
	output logic             last
);

	localparam int CAP_INT = (MAX_SPACE_RUN > 1023) ? 1023 : MAX_SPACE_RUN;
	localparam logic [RUN_W-1:0] SPACE_CAP = RUN_W'(CAP_INT);

	logic [1:0]       mode_q, mode_d;
	logic             slash_q, slash_d;
	logic             star_q, star_d;
	logic [RUN_W-1:0] count_q, count_d;
	logic [RUN_W-1:0] count_inc;

	result_t          q_mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q, rd_q;
	logic [Q_CNT_W-1:0] cnt_q;

	result_t res0, res1, code_res, slash_res;
	logic    v0, v1, code_v, run_code, pre_slash;
	logic    in_acc, out_acc;
	logic [1:0] n_push;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign count_inc = (count_q < SPACE_CAP) ? count_q + RUN_W'(1) : count_q;

	always_comb begin
		mode_d    = mode_q;
		slash_d   = slash_q;
		star_d    = star_q;
		count_d   = count_q;
		run_code  = 1'b0;
		pre_slash = 1'b0;
		code_v    = 1'b0;
		code_res  = '0;
		slash_res = '{space_run: '0, has_char: 1'b1, out_char: CH_SLASH, last: 1'b0};
		res0      = '0;
		res1      = '0;
		v0        = 1'b0;
		v1        = 1'b0;

		if (in_char == CH_NEWLINE) begin
			pre_slash = slash_q;
			slash_d   = 1'b0;
			star_d    = 1'b0;
			count_d   = '0;
			if (mode_q == MODE_LINE)
				mode_d = MODE_CODE;
		end else begin
			case (mode_q)
				MODE_CODE: begin
					if (slash_q) begin
						slash_d = 1'b0;
						if (in_char == CH_SLASH) begin
							mode_d = MODE_LINE;
						end else if (in_char == CH_STAR) begin
							mode_d = MODE_BLOCK;
							star_d = 1'b0;
						end else begin
							pre_slash = 1'b1;
							run_code  = 1'b1;
						end
					end else begin
						run_code = 1'b1;
					end
				end
				MODE_STRING: begin
					if (in_char == CH_SPACE) begin
						count_d = count_inc;
					end else begin
						if (in_char == CH_QUOTE)
							mode_d = MODE_CODE;
						code_v   = 1'b1;
						code_res = '{space_run: count_q, has_char: 1'b1,
							out_char: in_char, last: 1'b0};
						count_d  = '0;
					end
				end
				MODE_BLOCK: begin
					if (star_q && in_char == CH_SLASH) begin
						mode_d = MODE_CODE;
						star_d = 1'b0;
					end else begin
						star_d = (in_char == CH_STAR);
					end
				end
				default: begin
				end
			endcase
		end

		// ordinary code byte, with any held slash already dealt with
		if (run_code) begin
			if (in_char == CH_SPACE) begin
				count_d = count_inc;
			end else if (in_char == CH_SLASH) begin
				slash_d  = 1'b1;
				code_v   = (count_q != '0);
				code_res = '{space_run: count_q, has_char: 1'b0,
					out_char: 8'h00, last: 1'b0};
				count_d  = '0;
			end else begin
				if (in_char == CH_QUOTE)
					mode_d = MODE_STRING;
				code_v   = 1'b1;
				code_res = '{space_run: count_q, has_char: 1'b1,
					out_char: in_char, last: 1'b0};
				count_d  = '0;
			end
		end

		if (pre_slash) begin
			v0   = 1'b1;
			res0 = slash_res;
			v1   = code_v;
			res1 = code_res;
			res0.last = !code_v;
			res1.last = 1'b1;
		end else begin
			v0   = code_v;
			res0 = code_res;
			res0.last = 1'b1;
		end
	end

	assign n_push = {1'b0, in_acc && v0} + {1'b0, in_acc && v1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_CODE;
			slash_q <= 1'b0;
			star_q  <= 1'b0;
			count_q <= '0;
			wr_q    <= '0;
			rd_q    <= '0;
			cnt_q   <= '0;
		end else begin
			if (in_acc) begin
				mode_q  <= mode_d;
				slash_q <= slash_d;
				star_q  <= star_d;
				count_q <= count_d;
			end
			wr_q  <= wr_q + Q_PTR_W'(n_push);
			if (out_acc)
				rd_q <= rd_q + Q_PTR_W'(1);
			cnt_q <= cnt_q + Q_CNT_W'(n_push) - Q_CNT_W'(out_acc);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && v0)
			q_mem_q[wr_q] <= res0;
		if (in_acc && v1)
			q_mem_q[wr_q + Q_PTR_W'(1)] <= res1;
	end

	assign in_stall  = cnt_q > Q_CNT_W'(Q_DEPTH - 2);
	assign out_valid = cnt_q != '0;
	assign space_run = q_mem_q[rd_q].space_run;
	assign has_char  = q_mem_q[rd_q].has_char;
	assign out_char  = q_mem_q[rd_q].out_char;
	assign last      = q_mem_q[rd_q].last;

endmodule

// ===== sv/scs_checker.sv =====
`timescale 1ns / 1ps
module scs_checker
	import scs_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic [7:0]       in_char,
	input logic             out_valid,
	input logic             out_stall,
	input logic [RUN_W-1:0] space_run,
	input logic             has_char,
	input logic [7:0]       out_char,
	input logic             last
);

	// a stalled input beat holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_char))
		else $error("input beat changed under stall");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable({space_run, has_char, out_char, last}))
		else $error("result beat changed under stall");

	// a spaces-only beat carries a run and no byte
	a_spaces_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_char |-> space_run != '0 && out_char == 8'h00)
		else $error("spaces-only beat malformed");

	// spaces before a slash are the sole result of that byte
	a_spaces_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_char |-> last)
		else $error("spaces-only beat not last");

	a_no_newline: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_char |-> out_char != CH_NEWLINE)
		else $error("newline emitted");

endmodule

bind source_comment_stripper scs_checker u_scs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.in_char(in_char),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.space_run(space_run),
	.has_char(has_char),
	.out_char(out_char),
	.last(last)
);
